@@ rtl/damped_spring_force_3d_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef DAMPED_SPRING_FORCE_3D_TOP_ASSERT_SVH
`define DAMPED_SPRING_FORCE_3D_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold outside reset.
`define DSF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/dsf_pkg.sv @@
// ----------------------------------------------------------------------------
// dsf_pkg
// Types, constants and fixed-point helpers of the damped spring force engine.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAG_BITS  = 32;
    localparam int ROOT_BITS = 32;
    localparam int LEN_BITS  = 33;
    localparam int REM_BITS  = 34;
    localparam int QUO_BITS  = 18;
    localparam int CFG_BITS  = 31;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WMAX = 32'sh7FFF_FFFF;
    localparam word_t WMIN = 32'sh8000_0000;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_REST_LENGTH  = 2'd0,
        REG_STIFFNESS    = 2'd1,
        REG_DAMPING_GAIN = 2'd2,
        REG_SPRING_ON    = 2'd3
    } reg_idx_t;

    // Sideband that travels with a transaction through root and divide steps.
    typedef struct packed {
        logic [2:0][MAG_BITS-1:0] mag;
        logic [2:0]               neg;
        logic                     shift;
        logic [2:0][WORD_BITS-1:0] vel;
        logic                     free_first;
        logic                     free_second;
        logic                     active;
    } carry_t;

    // Divider working state for the three direction components.
    typedef struct packed {
        logic [2:0][REM_BITS-1:0] rem;
        logic [2:0][QUO_BITS-1:0] quo;
        logic [LEN_BITS-1:0]      len;
    } div_t;

    // Shift a product magnitude down, apply the sign and saturate.
    function automatic word_t mulq_fin(input logic [63:0] prod, input logic neg);
        logic [47:0] q;
        word_t       r;
        q = prod[63:FRAC_BITS];
        if (neg) begin
            r = (q >= 48'h0000_8000_0000) ? WMIN : word_t'(-q[31:0]);
        end
        else begin
            r = (q > 48'h0000_7FFF_FFFF) ? WMAX : word_t'(q[31:0]);
        end
        return r;
    endfunction

    function automatic word_t neg_sat(input word_t a);
        return (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic word_t add_sat(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        word_t                     r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r = s[WORD_BITS] ? WMIN : WMAX;
        end
        else begin
            r = word_t'(s[WORD_BITS-1:0]);
        end
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] abs_word(input word_t a);
        return a[WORD_BITS-1] ? 32'(-a) : 32'(a);
    endfunction

endpackage

@@ rtl/dsf_root_step.sv @@
// ----------------------------------------------------------------------------
// dsf_root_step
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module dsf_root_step
    import dsf_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [63:0] rad_in,
    input  logic [63:0] res_in,
    input  carry_t      carry_in,
    output logic        valid_out,
    output logic [63:0] rad_out,
    output logic [63:0] res_out,
    output carry_t      carry_out
);

    localparam logic [63:0] BIT = 64'd1 << (2 * STEP);

    logic        valid_reg;
    logic [63:0] rad_reg, rad_next;
    logic [63:0] res_reg, res_next;
    carry_t      carry_reg;
    logic [63:0] trial;

    // Try to subtract the current root estimate plus the step bit.
    always_comb
    begin
        trial = res_in + BIT;
        if (rad_in >= trial)
        begin
            rad_next = rad_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            rad_next = rad_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg   <= rad_next;
        res_reg   <= res_next;
        carry_reg <= carry_in;
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign res_out   = res_reg;
    assign carry_out = carry_reg;

endmodule

@@ rtl/dsf_div_step.sv @@
// ----------------------------------------------------------------------------
// dsf_div_step
// One registered quotient bit of the three direction dividers.
// ----------------------------------------------------------------------------
module dsf_div_step
    import dsf_pkg::*;
#(
    parameter int BIT_POS = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid_in,
    input  div_t   div_in,
    input  carry_t carry_in,
    output logic   valid_out,
    output div_t   div_out,
    output carry_t carry_out
);

    // The dividend is the magnitude shifted up by the fraction bits.
    localparam int   SRC = (BIT_POS >= FRAC_BITS) ? BIT_POS - FRAC_BITS : 0;
    localparam logic HAS = (BIT_POS >= FRAC_BITS);

    logic   valid_reg;
    div_t   div_reg, div_next;
    carry_t carry_reg;
    logic [REM_BITS-1:0] shifted;
    logic [REM_BITS-1:0] len_ext;
    logic                nbit;

    always_comb
    begin
        div_next     = div_in;
        len_ext      = {1'b0, div_in.len};
        shifted      = '0;
        nbit         = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nbit    = HAS & carry_in.mag[i][SRC];
            shifted = {div_in.rem[i][REM_BITS-2:0], nbit};
            if (shifted >= len_ext)
            begin
                div_next.rem[i] = shifted - len_ext;
                div_next.quo[i] = {div_in.quo[i][QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                div_next.rem[i] = shifted;
                div_next.quo[i] = {div_in.quo[i][QUO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        carry_reg <= carry_in;
    end

    assign valid_out = valid_reg;
    assign div_out   = div_reg;
    assign carry_out = carry_reg;

endmodule

@@ rtl/damped_spring_force_3d_top.sv @@
// ----------------------------------------------------------------------------
// damped_spring_force_3d_top
// Pipelined damped Hooke spring force between two 3D end points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the positions, relative velocity and free flags and
//   pulse start; a transaction is accepted on every edge with start high and
//   busy low. busy is always low, so one spring can enter every cycle.
//   Result channel: done is high for exactly one cycle with the forces and
//   add flags; the result is taken at the edge that ends that cycle.
//   Throughput: one spring per cycle. done follows the accepting edge through
//   stages A to D, the 32 square-root steps, stage L, the 18 quotient-bit steps
//   of the direction dividers, the multiply stages M1 to M6 and the output register.
//   Configuration: APB writes to rest_length, stiffness, damping_gain and
//   spring_on at byte addresses 0, 4, 8 and 12; write only when the pipeline
//   holds no transaction.
//   Reset: rst_n clears the pipeline valid bits and loads the register
//   defaults (rest 0.75, stiffness 2.0, damping 1.0, spring on). The
//   receiver cannot stall, so results leave as they complete.
// ----------------------------------------------------------------------------
module damped_spring_force_3d_top
    import dsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  logic signed [31:0] rel_vel_x,
    input  logic signed [31:0] rel_vel_y,
    input  logic signed [31:0] rel_vel_z,
    input  logic        first_free,
    input  logic        second_free,
    output logic        done,
    output logic signed [31:0] force_first_x,
    output logic signed [31:0] force_first_y,
    output logic signed [31:0] force_first_z,
    output logic signed [31:0] force_second_x,
    output logic signed [31:0] force_second_y,
    output logic signed [31:0] force_second_z,
    output logic        add_first,
    output logic        add_second
);

    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = QUO_BITS;

    // Configuration registers.
    logic [CFG_BITS-1:0] rest_length_reg;
    logic [CFG_BITS-1:0] stiffness_reg;
    logic [CFG_BITS-1:0] damping_gain_reg;
    logic                spring_on_reg;
    reg_idx_t            reg_idx;

    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_length_reg  <= 31'd49152;
            stiffness_reg    <= 31'd131072;
            damping_gain_reg <= 31'd65536;
            spring_on_reg    <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_REST_LENGTH:  rest_length_reg  <= pwdata[CFG_BITS-1:0];
                REG_STIFFNESS:    stiffness_reg    <= pwdata[CFG_BITS-1:0];
                REG_DAMPING_GAIN: damping_gain_reg <= pwdata[CFG_BITS-1:0];
                REG_SPRING_ON:    spring_on_reg    <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (reg_idx)
            REG_REST_LENGTH:  prdata = {1'b0, rest_length_reg};
            REG_STIFFNESS:    prdata = {1'b0, stiffness_reg};
            REG_DAMPING_GAIN: prdata = {1'b0, damping_gain_reg};
            REG_SPRING_ON:    prdata = {31'd0, spring_on_reg};
            default:          prdata = '0;
        endcase
    end

    // Stage A: end point differences.
    logic                    a_valid_reg;
    logic [2:0][32:0]        a_diff_reg;
    logic [2:0][31:0]        a_vel_reg;
    logic                    a_f1_reg, a_f2_reg, a_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_diff_reg[0] <= {first_x[31], first_x} - {second_x[31], second_x};
        a_diff_reg[1] <= {first_y[31], first_y} - {second_y[31], second_y};
        a_diff_reg[2] <= {first_z[31], first_z} - {second_z[31], second_z};
        a_vel_reg[0]  <= rel_vel_x;
        a_vel_reg[1]  <= rel_vel_y;
        a_vel_reg[2]  <= rel_vel_z;
        a_f1_reg      <= first_free;
        a_f2_reg      <= second_free;
        a_active_reg  <= spring_on_reg && (first_free || second_free);
    end

    // Stage B: magnitudes, signs and the range shift.
    logic   b_valid_reg;
    carry_t b_carry_reg, b_carry_next;

    always_comb
    begin
        logic [32:0] m;
        b_carry_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = a_diff_reg[i][32] ? 33'(-a_diff_reg[i]) : a_diff_reg[i];
            b_carry_next.mag[i] = m[MAG_BITS-1:0];
            b_carry_next.neg[i] = a_diff_reg[i][32];
            b_carry_next.vel[i] = a_vel_reg[i];
        end
        b_carry_next.shift       = b_carry_next.mag[0][31] | b_carry_next.mag[1][31]
                                 | b_carry_next.mag[2][31];
        b_carry_next.free_first  = a_f1_reg;
        b_carry_next.free_second = a_f2_reg;
        b_carry_next.active      = a_active_reg;
    end

    // Stage C: squares of the scaled magnitudes.
    logic                c_valid_reg;
    carry_t              c_carry_reg;
    logic [2:0][63:0]    c_sq_reg;
    logic [2:0][31:0]    c_scaled;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_scaled[i] = b_carry_reg.mag[i] >> b_carry_reg.shift;
        end
    end

    // Stage D: sum of squares.
    logic        d_valid_reg;
    carry_t      d_carry_reg;
    logic [63:0] d_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_carry_reg <= b_carry_next;
        c_carry_reg <= b_carry_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_sq_reg[i] <= c_scaled[i] * c_scaled[i];
        end
        d_carry_reg <= c_carry_reg;
        d_sum_reg   <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
    end

    // Square root, one result bit per stage.
    logic        root_valid [0:ROOT_STEPS];
    logic [63:0] root_rad   [0:ROOT_STEPS];
    logic [63:0] root_res   [0:ROOT_STEPS];
    carry_t      root_carry [0:ROOT_STEPS];

    assign root_valid[0] = d_valid_reg;
    assign root_rad[0]   = d_sum_reg;
    assign root_res[0]   = '0;
    assign root_carry[0] = d_carry_reg;

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_root
        dsf_root_step #(.STEP(ROOT_STEPS - 1 - g)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (root_valid[g]),
            .rad_in    (root_rad[g]),
            .res_in    (root_res[g]),
            .carry_in  (root_carry[g]),
            .valid_out (root_valid[g+1]),
            .rad_out   (root_rad[g+1]),
            .res_out   (root_res[g+1]),
            .carry_out (root_carry[g+1])
        );
    end

    // Stage L: length and divider setup.
    logic   l_valid_reg;
    carry_t l_carry_reg;
    div_t   l_div_reg, l_div_next;

    always_comb
    begin
        logic [ROOT_BITS-1:0] root;
        root = root_res[ROOT_STEPS][ROOT_BITS-1:0];
        l_div_next     = '0;
        l_div_next.len = root_carry[ROOT_STEPS].shift ? {root, 1'b0} : {1'b0, root};
        for (int i = 0; i < 3; i++)
        begin
            l_div_next.rem[i] = REM_BITS'(root_carry[ROOT_STEPS].mag[i] >> 2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else
        begin
            l_valid_reg <= root_valid[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        l_carry_reg <= root_carry[ROOT_STEPS];
        l_div_reg   <= l_div_next;
    end

    // Direction dividers, one quotient bit per stage.
    logic   div_valid [0:DIV_STEPS];
    div_t   div_state [0:DIV_STEPS];
    carry_t div_carry [0:DIV_STEPS];

    assign div_valid[0] = l_valid_reg;
    assign div_state[0] = l_div_reg;
    assign div_carry[0] = l_carry_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        dsf_div_step #(.BIT_POS(DIV_STEPS - 1 - g)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (div_valid[g]),
            .div_in    (div_state[g]),
            .carry_in  (div_carry[g]),
            .valid_out (div_valid[g+1]),
            .div_out   (div_state[g+1]),
            .carry_out (div_carry[g+1])
        );
    end

    // Stage M1: unit vector, stretch and velocity magnitudes.
    logic                     m1_valid_reg;
    logic [2:0][QUO_BITS-1:0] m1_umag_reg;
    logic [2:0]               m1_uneg_reg;
    logic [2:0][31:0]         m1_vmag_reg;
    logic [2:0]               m1_vneg_reg;
    logic [32:0]              m1_smag_reg;
    logic                     m1_sneg_reg;
    logic                     m1_f1_reg, m1_f2_reg, m1_act_reg;
    logic signed [33:0]       m1_stretch;

    assign m1_stretch = $signed({1'b0, div_state[DIV_STEPS].len})
                      - $signed({3'b0, rest_length_reg});

    // Stage M2: spring and damping dot products.
    logic                     m2_valid_reg;
    logic [63:0]              m2_sprod_reg;
    logic                     m2_sneg_reg;
    logic [2:0][63:0]         m2_dprod_reg;
    logic [2:0]               m2_dneg_reg;
    logic [2:0][QUO_BITS-1:0] m2_umag_reg;
    logic [2:0]               m2_uneg_reg;
    logic                     m2_f1_reg, m2_f2_reg, m2_act_reg;

    // Stage M3: spring force and saturated dot sum.
    logic                     m3_valid_reg;
    word_t                    m3_spring_reg, m3_dot_reg;
    logic [2:0][QUO_BITS-1:0] m3_umag_reg;
    logic [2:0]               m3_uneg_reg;
    logic                     m3_f1_reg, m3_f2_reg, m3_act_reg;
    word_t                    m3_dot_next;

    always_comb
    begin
        m3_dot_next = add_sat(add_sat(mulq_fin(m2_dprod_reg[0], m2_dneg_reg[0]),
                                      mulq_fin(m2_dprod_reg[1], m2_dneg_reg[1])),
                              mulq_fin(m2_dprod_reg[2], m2_dneg_reg[2]));
    end

    // Stage M4: damping product.
    logic                     m4_valid_reg;
    word_t                    m4_spring_reg;
    logic [63:0]              m4_dprod_reg;
    logic                     m4_dneg_reg;
    logic [2:0][QUO_BITS-1:0] m4_umag_reg;
    logic [2:0]               m4_uneg_reg;
    logic                     m4_f1_reg, m4_f2_reg, m4_act_reg;

    // Stage M5: scalar force.
    logic                     m5_valid_reg;
    word_t                    m5_r_reg;
    logic [2:0][QUO_BITS-1:0] m5_umag_reg;
    logic [2:0]               m5_uneg_reg;
    logic                     m5_f1_reg, m5_f2_reg, m5_act_reg;

    // Stage M6: force components.
    logic                     m6_valid_reg;
    logic [2:0][63:0]         m6_prod_reg;
    logic [2:0]               m6_neg_reg;
    logic                     m6_f1_reg, m6_f2_reg, m6_act_reg;
    logic [31:0]              m6_rmag;

    assign m6_rmag = abs_word(m5_r_reg);

    // Stage M7: output registers.
    logic                     done_reg;
    word_t [2:0]              ff_reg, fs_reg;
    logic                     add_first_reg, add_second_reg;
    word_t [2:0]              first_next;
    logic                     add_first_next, add_second_next;

    always_comb
    begin
        add_first_next  = m6_valid_reg && m6_act_reg && m6_f1_reg;
        add_second_next = m6_valid_reg && m6_act_reg && m6_f2_reg;
        for (int i = 0; i < 3; i++)
        begin
            first_next[i] = mulq_fin(m6_prod_reg[i], m6_neg_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg   <= 1'b0;
            m2_valid_reg   <= 1'b0;
            m3_valid_reg   <= 1'b0;
            m4_valid_reg   <= 1'b0;
            m5_valid_reg   <= 1'b0;
            m6_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            add_first_reg  <= 1'b0;
            add_second_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg   <= div_valid[DIV_STEPS];
            m2_valid_reg   <= m1_valid_reg;
            m3_valid_reg   <= m2_valid_reg;
            m4_valid_reg   <= m3_valid_reg;
            m5_valid_reg   <= m4_valid_reg;
            m6_valid_reg   <= m5_valid_reg;
            done_reg       <= m6_valid_reg;
            add_first_reg  <= add_first_next;
            add_second_reg <= add_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // M1
        for (int i = 0; i < 3; i++)
        begin
            m1_umag_reg[i] <= (div_state[DIV_STEPS].len == '0) ? '0
                                                                : div_state[DIV_STEPS].quo[i];
            m1_uneg_reg[i] <= div_carry[DIV_STEPS].neg[i];
            m1_vmag_reg[i] <= abs_word(div_carry[DIV_STEPS].vel[i]);
            m1_vneg_reg[i] <= div_carry[DIV_STEPS].vel[i][31];
        end
        m1_smag_reg <= m1_stretch[33] ? 33'(-m1_stretch) : m1_stretch[32:0];
        m1_sneg_reg <= m1_stretch[33];
        m1_f1_reg   <= div_carry[DIV_STEPS].free_first;
        m1_f2_reg   <= div_carry[DIV_STEPS].free_second;
        m1_act_reg  <= div_carry[DIV_STEPS].active;

        // M2
        m2_sprod_reg <= m1_smag_reg * stiffness_reg;
        m2_sneg_reg  <= m1_sneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            m2_dprod_reg[i] <= 64'(m1_umag_reg[i] * m1_vmag_reg[i]);
            m2_dneg_reg[i]  <= m1_uneg_reg[i] ^ m1_vneg_reg[i];
        end
        m2_umag_reg <= m1_umag_reg;
        m2_uneg_reg <= m1_uneg_reg;
        m2_f1_reg   <= m1_f1_reg;
        m2_f2_reg   <= m1_f2_reg;
        m2_act_reg  <= m1_act_reg;

        // M3
        m3_spring_reg <= neg_sat(mulq_fin(m2_sprod_reg, m2_sneg_reg));
        m3_dot_reg    <= m3_dot_next;
        m3_umag_reg   <= m2_umag_reg;
        m3_uneg_reg   <= m2_uneg_reg;
        m3_f1_reg     <= m2_f1_reg;
        m3_f2_reg     <= m2_f2_reg;
        m3_act_reg    <= m2_act_reg;

        // M4
        m4_spring_reg <= m3_spring_reg;
        m4_dprod_reg  <= damping_gain_reg * abs_word(m3_dot_reg);
        m4_dneg_reg   <= m3_dot_reg[31];
        m4_umag_reg   <= m3_umag_reg;
        m4_uneg_reg   <= m3_uneg_reg;
        m4_f1_reg     <= m3_f1_reg;
        m4_f2_reg     <= m3_f2_reg;
        m4_act_reg    <= m3_act_reg;

        // M5
        m5_r_reg    <= add_sat(m4_spring_reg, neg_sat(mulq_fin(m4_dprod_reg, m4_dneg_reg)));
        m5_umag_reg <= m4_umag_reg;
        m5_uneg_reg <= m4_uneg_reg;
        m5_f1_reg   <= m4_f1_reg;
        m5_f2_reg   <= m4_f2_reg;
        m5_act_reg  <= m4_act_reg;

        // M6
        for (int i = 0; i < 3; i++)
        begin
            m6_prod_reg[i] <= 64'(m5_umag_reg[i] * m6_rmag);
            m6_neg_reg[i]  <= m5_uneg_reg[i] ^ m5_r_reg[31];
        end
        m6_f1_reg  <= m5_f1_reg;
        m6_f2_reg  <= m5_f2_reg;
        m6_act_reg <= m5_act_reg;

        // M7
        for (int i = 0; i < 3; i++)
        begin
            ff_reg[i] <= add_first_next ? first_next[i] : '0;
            fs_reg[i] <= add_second_next ? neg_sat(first_next[i]) : '0;
        end
    end

    assign done           = done_reg;
    assign add_first      = add_first_reg;
    assign add_second     = add_second_reg;
    assign force_first_x  = ff_reg[0];
    assign force_first_y  = ff_reg[1];
    assign force_first_z  = ff_reg[2];
    assign force_second_x = fs_reg[0];
    assign force_second_y = fs_reg[1];
    assign force_second_z = fs_reg[2];

endmodule

@@ rtl/dsf_checker.sv @@
// ----------------------------------------------------------------------------
// dsf_checker
// Port-level checks of the spring force engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "damped_spring_force_3d_top_assert.svh"

module dsf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic signed [31:0] force_first_x,
    input logic signed [31:0] force_first_y,
    input logic signed [31:0] force_first_z,
    input logic signed [31:0] force_second_x,
    input logic signed [31:0] force_second_y,
    input logic signed [31:0] force_second_z,
    input logic        add_first,
    input logic        add_second
);

    // An end that is not free receives no force.
    `DSF_ASSERT_IMPLY(a_first_idle, clk, rst_n, done && !add_first, force_first_x == 0 && force_first_y == 0 && force_first_z == 0, "first force nonzero without add_first")
    `DSF_ASSERT_IMPLY(a_second_idle, clk, rst_n, done && !add_second, force_second_x == 0 && force_second_y == 0 && force_second_z == 0, "second force nonzero without add_second")

    // The second end gets the negated first force, saturated at the most positive value.
    `DSF_ASSERT_IMPLY(a_opposite, clk, rst_n, done && add_first && add_second, (force_first_x + force_second_x == 0) || (force_first_x == 32'sh8000_0000), "forces on the ends are not opposite")

    // Add flags only accompany a result transaction.
    `DSF_ASSERT_NEVER(a_flag_strobe, clk, rst_n, !done && (add_first || add_second), "add flag outside a result")

    // The engine takes a new transaction every cycle.
    `DSF_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy asserted")

endmodule

bind damped_spring_force_3d_top dsf_checker u_dsf_checker (.*);

@@ test/tb_damped_spring_force_3d_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for damped_spring_force_3d_top
// Drives spring transactions with random gaps, predicts each force result in
// plain SystemVerilog arithmetic and checks every result field by field.
// Register settings are changed over APB between phases while idle.
// ----------------------------------------------------------------------------
module tb_damped_spring_force_3d_top
    import dsf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 62;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        logic signed [31:0] vel [3];
        logic               free1;
        logic               free2;
    } spring_in_t;

    typedef struct {
        logic signed [31:0] f1 [3];
        logic signed [31:0] f2 [3];
        logic               add1;
        logic               add2;
    } spring_force_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy, done;
    logic signed [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
    logic signed [31:0] rel_vel_x, rel_vel_y, rel_vel_z;
    logic first_free, second_free;
    logic signed [31:0] force_first_x, force_first_y, force_first_z;
    logic signed [31:0] force_second_x, force_second_y, force_second_z;
    logic add_first, add_second;

    // Model copy of the register file.
    logic [30:0] m_rest, m_stiff, m_damp;
    logic        m_on;

    spring_in_t    pending_springs [$];
    spring_force_t expected_forces [$];
    int  errors;
    int  cycles;
    int  results_seen;
    bit  calm;

    damped_spring_force_3d_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Fixed-point product: truncate toward zero, then saturate to a word.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [127:0] q;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        q = p >> FRAC_BITS;
        if (neg)
            return (q >= 128'h8000_0000) ? -64'sd2147483648 : -longint'(q[63:0]);
        return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q[63:0]);
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_neg(longint v);
        return sat_word(-v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Predict the forces on both ends for one spring transaction.
    function automatic spring_force_t spring_forces(spring_in_t s);
        spring_force_t r;
        longint d [3];
        longint u [3];
        longint mx, len, spring, dot, sc, t;
        logic [63:0] sum, a, q;
        int sh;
        for (int i = 0; i < 3; i++)
        begin
            r.f1[i] = 0;
            r.f2[i] = 0;
        end
        r.add1 = 0;
        r.add2 = 0;
        if (!m_on || (!s.free1 && !s.free2))
            return r;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'(s.p1[i]) - longint'(s.p2[i]);
            t = d[i] < 0 ? -d[i] : d[i];
            if (t > mx)
                mx = t;
        end
        sh = (mx >= 64'sd2147483648) ? 1 : 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = 64'(d[i] < 0 ? -d[i] : d[i]) >> sh;
            sum += a * a;
        end
        len = longint'(int_sqrt(sum) << sh);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                u[i] = 0;
            else
            begin
                q = (64'(d[i] < 0 ? -d[i] : d[i]) << FRAC_BITS) / 64'(len);
                u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
        spring = fx_neg(fx_mul(len - longint'(m_rest), longint'(m_stiff)));
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot = sat_word(dot + fx_mul(u[i], longint'(s.vel[i])));
        sc = sat_word(spring + fx_neg(fx_mul(longint'(m_damp), dot)));
        for (int i = 0; i < 3; i++)
        begin
            t = fx_mul(u[i], sc);
            if (s.free1)
                r.f1[i] = 32'(t);
            if (s.free2)
                r.f2[i] = 32'(fx_neg(t));
        end
        r.add1 = s.free1;
        r.add2 = s.free2;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_coord(int mode);
        case (mode)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            3: return 32'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic spring_in_t random_spring();
        spring_in_t s;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            s.p1[i] = pick_coord(mode < 7 ? $urandom_range(2, 3) : $urandom_range(0, 4));
            s.p2[i] = pick_coord(mode < 7 ? $urandom_range(2, 3) : $urandom_range(0, 4));
            s.vel[i] = pick_coord(mode < 5 ? 2 : $urandom_range(0, 4));
        end
        // Occasionally make the two ends coincide.
        if (mode == 9)
            s.p2 = s.p1;
        s.free1 = $urandom_range(0, 1);
        s.free2 = $urandom_range(0, 1);
        return s;
    endfunction

    // APB write of one register during a quiet pipeline.
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REST_LENGTH:  m_rest  = val[30:0];
            REG_STIFFNESS:    m_stiff = val[30:0];
            REG_DAMPING_GAIN: m_damp  = val[30:0];
            REG_SPRING_ON:    m_on    = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_springs.size() != 0 || expected_forces.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Driver: present queued transactions with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            spring_in_t s;
            if (start && !busy)
            begin
                s = pending_springs.pop_front();
                expected_forces.push_back(spring_forces(s));
            end
            if (pending_springs.size() != 0 && (calm || $urandom_range(0, 99) >= 38))
            begin
                s = pending_springs[0];
                first_x <= s.p1[0]; first_y <= s.p1[1]; first_z <= s.p1[2];
                second_x <= s.p2[0]; second_y <= s.p2[1]; second_z <= s.p2[2];
                rel_vel_x <= s.vel[0]; rel_vel_y <= s.vel[1]; rel_vel_z <= s.vel[2];
                first_free <= s.free1;
                second_free <= s.free2;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            spring_force_t e;
            logic signed [31:0] got [8];
            logic signed [31:0] want [8];
            results_seen++;
            if (expected_forces.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $realtime);
                errors++;
            end
            else
            begin
                e = expected_forces.pop_front();
                got = '{force_first_x, force_first_y, force_first_z,
                        force_second_x, force_second_y, force_second_z,
                        32'(add_first), 32'(add_second)};
                want = '{e.f1[0], e.f1[1], e.f1[2], e.f2[0], e.f2[1], e.f2[2],
                         32'(e.add1), 32'(e.add2)};
                for (int i = 0; i < 8; i++)
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $realtime, i, want[i], got[i]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_directed();
        spring_in_t s;
        // Zero length, both free.
        s.p1 = '{32'sh10000, 32'sh20000, -32'sh30000};
        s.p2 = s.p1;
        s.vel = '{32'sh10000, 0, 0};
        s.free1 = 1; s.free2 = 1;
        pending_springs.push_back(s);
        // Neither end free.
        s.p2 = '{0, 0, 0};
        s.free1 = 0; s.free2 = 0;
        pending_springs.push_back(s);
        // One end free each way.
        s.free1 = 1; pending_springs.push_back(s);
        s.free1 = 0; s.free2 = 1; pending_springs.push_back(s);
        // Opposite extremes: differences beyond 31 bits.
        s.p1 = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        s.p2 = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        s.vel = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        s.free1 = 1; s.free2 = 1;
        pending_springs.push_back(s);
        s.p1 = s.p2; s.p2 = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        pending_springs.push_back(s);
        // Axis-aligned unit springs.
        for (int i = 0; i < 3; i++)
        begin
            s.p1 = '{0, 0, 0};
            s.p2 = '{0, 0, 0};
            s.p1[i] = 32'sh10000;
            s.vel = '{32'sh8000, -32'sh8000, 32'sh4000};
            pending_springs.push_back(s);
        end
        for (int i = 0; i < 8; i++)
            pending_springs.push_back(random_spring());
    endtask

    initial
    begin
        logic [31:0] reg_vals [4][4];
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        start = 0;
        first_x = 0; first_y = 0; first_z = 0;
        second_x = 0; second_y = 0; second_z = 0;
        rel_vel_x = 0; rel_vel_y = 0; rel_vel_z = 0;
        first_free = 0; second_free = 0;
        errors = 0; cycles = 0; results_seen = 0; calm = 0;
        m_rest = 31'h0000_C000; m_stiff = 31'h0002_0000; m_damp = 31'h0001_0000; m_on = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Phase with reset settings, directed then random.
        push_directed();
        for (int i = 0; i < 300; i++)
            pending_springs.push_back(random_spring());
        wait_drained();

        // Settings per phase: rest, stiffness, damping, enable.
        reg_vals = '{'{32'h0, 32'h0, 32'h0, 32'h1},
                     '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1},
                     '{32'h0003_0000, 32'h0000_8000, 32'h0010_0000, 32'h0},
                     '{32'h0001_8000, 32'h0005_0000, 32'h0000_4000, 32'h1}};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_REST_LENGTH, reg_vals[ph][0]);
            write_reg(REG_STIFFNESS, reg_vals[ph][1]);
            write_reg(REG_DAMPING_GAIN, reg_vals[ph][2]);
            write_reg(REG_SPRING_ON, reg_vals[ph][3]);
            calm = (ph == 1);
            if (ph == 1)
                push_directed();
            for (int i = 0; i < 330; i++)
                pending_springs.push_back(random_spring());
            wait_drained();
        end

        $display("Covered %0d spring results over five register settings,", results_seen);
        $display("including disabled spring, extreme gains and coincident ends.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
